// File: rtl/tdci_pkg.sv
// Shared constants, command codes and types of the text display interpreter.
`timescale 1ns / 1ps
package tdci_pkg;

  // Display geometry
  localparam int NUM_COLS = 80;
  localparam int NUM_ROWS = 25;
  localparam int NUM_CELLS = NUM_ROWS * NUM_COLS;
  localparam int ADDR_W = $clog2(NUM_CELLS);

  // Field widths
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int CHAR_W = 7;
  localparam int BYTE_W = 8;
  localparam int REPLY_W = 2;
  localparam int CMD_W = 4;

  // Line bytes
  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] BYTE_ENQ = 8'h05;
  localparam logic [BYTE_W-1:0] BYTE_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] BYTE_BS = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] BYTE_FF = 8'h0c;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_DC1 = 8'h11;
  localparam logic [BYTE_W-1:0] BYTE_DC3 = 8'h13;
  localparam logic [BYTE_W-1:0] BYTE_DC4 = 8'h14;
  localparam logic [BYTE_W-1:0] BYTE_RS = 8'h1e;
  localparam logic [BYTE_W-1:0] BYTE_US = 8'h1f;
  localparam logic [BYTE_W-1:0] BYTE_PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_PRINT_HI = 8'h7e;

  // Stored characters
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_ETX = 7'h03;
  localparam logic [CHAR_W-1:0] CHAR_CR = 7'h0d;

  // Operation field
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Reply codes
  localparam logic [REPLY_W-1:0] REPLY_NONE = 2'd0;
  localparam logic [REPLY_W-1:0] REPLY_ACK = 2'd1;
  localparam logic [REPLY_W-1:0] REPLY_GRANT = 2'd2;

  // Classified commands
  localparam logic [CMD_W-1:0] CMD_READ = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ACK = 4'd1;
  localparam logic [CMD_W-1:0] CMD_EOT = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ENQ = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STX = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ETX = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PRINT = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DC1 = 4'd7;
  localparam logic [CMD_W-1:0] CMD_BS = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DC4 = 4'd9;
  localparam logic [CMD_W-1:0] CMD_DC3 = 4'd10;
  localparam logic [CMD_W-1:0] CMD_LF = 4'd11;
  localparam logic [CMD_W-1:0] CMD_CR = 4'd12;
  localparam logic [CMD_W-1:0] CMD_FF = 4'd13;
  localparam logic [CMD_W-1:0] CMD_NUL = 4'd14;
  localparam logic [CMD_W-1:0] CMD_OTHER = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic [REPLY_W-1:0] reply;
    logic [CHAR_W-1:0]  cell_char;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic               in_text;
    logic               unexpected;
  } res_t;

endpackage

// File: rtl/tdci_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tdci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tdci_front.sv
// Front end: decodes incoming items into commands and queues them for the back end.
`timescale 1ns / 1ps
module tdci_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_operation,
  input  logic [tdci_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic [tdci_pkg::ROW_W-1:0]   in_read_row,
  input  logic [tdci_pkg::COL_W-1:0]   in_read_col,
  input  logic                         hold,
  output logic                         cmd_valid,
  output tdci_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);

  tdci_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           wr_en, rd_en;
  logic           printable;
  tdci_pkg::cmd_t dec;

  // classify
  always_comb begin
    printable = ((in_rx_byte >= tdci_pkg::BYTE_PRINT_LO) &&
                 (in_rx_byte <= tdci_pkg::BYTE_PRINT_HI)) ||
                (in_rx_byte == tdci_pkg::BYTE_RS) || (in_rx_byte == tdci_pkg::BYTE_US);
    dec.ch = in_rx_byte[tdci_pkg::CHAR_W-1:0];
    dec.row = in_read_row;
    dec.col = in_read_col;
    dec.in_range = (32'(in_read_row) < tdci_pkg::NUM_ROWS) &&
                   (32'(in_read_col) < tdci_pkg::NUM_COLS);
    if (in_operation == tdci_pkg::OP_READ) begin
      dec.code = tdci_pkg::CMD_READ;
    end else begin
      case (in_rx_byte)
        tdci_pkg::BYTE_ACK: dec.code = tdci_pkg::CMD_ACK;
        tdci_pkg::BYTE_EOT: dec.code = tdci_pkg::CMD_EOT;
        tdci_pkg::BYTE_ENQ: dec.code = tdci_pkg::CMD_ENQ;
        tdci_pkg::BYTE_STX: dec.code = tdci_pkg::CMD_STX;
        tdci_pkg::BYTE_ETX: dec.code = tdci_pkg::CMD_ETX;
        tdci_pkg::BYTE_DC1: dec.code = tdci_pkg::CMD_DC1;
        tdci_pkg::BYTE_BS:  dec.code = tdci_pkg::CMD_BS;
        tdci_pkg::BYTE_DC4: dec.code = tdci_pkg::CMD_DC4;
        tdci_pkg::BYTE_DC3: dec.code = tdci_pkg::CMD_DC3;
        tdci_pkg::BYTE_LF:  dec.code = tdci_pkg::CMD_LF;
        tdci_pkg::BYTE_CR:  dec.code = tdci_pkg::CMD_CR;
        tdci_pkg::BYTE_FF:  dec.code = tdci_pkg::CMD_FF;
        tdci_pkg::BYTE_NUL: dec.code = tdci_pkg::CMD_NUL;
        default: dec.code = printable ? tdci_pkg::CMD_PRINT : tdci_pkg::CMD_OTHER;
      endcase
    end
  end

  // two-entry command queue
  assign full = (count_r == 2'd2) || hold;
  assign wr_en = push && !full;
  assign cmd_valid = (count_r != 2'd0);
  assign rd_en = cmd_pop && cmd_valid;
  assign cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt = count_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/tdci_back.sv
// Back end: executes commands on the cursor and cell store, holds the result register.
`timescale 1ns / 1ps
module tdci_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tdci_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           init_busy,
  output logic           res_valid,
  output tdci_pkg::res_t res,
  input  logic           res_pop
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_ERASE = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [tdci_pkg::ROW_W-1:0] LAST_ROW = tdci_pkg::ROW_W'(tdci_pkg::NUM_ROWS - 1);
  localparam logic [tdci_pkg::COL_W-1:0] LAST_COL = tdci_pkg::COL_W'(tdci_pkg::NUM_COLS - 1);
  localparam logic [tdci_pkg::ADDR_W-1:0] LAST_ADDR =
    tdci_pkg::ADDR_W'(tdci_pkg::NUM_CELLS - 1);

  function automatic logic [tdci_pkg::ADDR_W-1:0] cell_addr(
    input logic [tdci_pkg::ROW_W-1:0] r,
    input logic [tdci_pkg::COL_W-1:0] c
  );
    cell_addr = tdci_pkg::ADDR_W'(r) * tdci_pkg::ADDR_W'(tdci_pkg::NUM_COLS) +
                tdci_pkg::ADDR_W'(c);
  endfunction

  logic [2:0]                    state_r, state_nxt;
  logic [tdci_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [tdci_pkg::COL_W-1:0]    col_r, col_nxt;
  logic                          text_r, text_nxt;
  logic [tdci_pkg::ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                          clr_emit_r, clr_emit_nxt;
  logic [tdci_pkg::COL_W-1:0]    ers_col_r, ers_col_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  logic                          out_valid_r;
  tdci_pkg::res_t                out_r;

  logic                          out_free, emit;
  tdci_pkg::res_t                emit_res;
  logic [tdci_pkg::REPLY_W-1:0]  em_reply;
  logic [tdci_pkg::CHAR_W-1:0]   em_cell;
  logic                          em_odd;
  logic                          ram_we, ram_re;
  logic [tdci_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [tdci_pkg::CHAR_W-1:0]   ram_wdata, ram_rdata;

  // cursor neighbors
  logic [tdci_pkg::ROW_W-1:0]    row_dn, row_up, right_row, right_row_dn, left_row;
  logic [tdci_pkg::COL_W-1:0]    right_col, left_col;

  always_comb begin
    row_dn = (row_r == LAST_ROW) ? '0 : row_r + 1'b1;
    row_up = (row_r == '0) ? LAST_ROW : row_r - 1'b1;
    right_row = (col_r == LAST_COL) ? row_dn : row_r;
    right_col = (col_r == LAST_COL) ? '0 : col_r + 1'b1;
    right_row_dn = (right_row == LAST_ROW) ? '0 : right_row + 1'b1;
    left_row = (col_r == '0) ? row_up : row_r;
    left_col = (col_r == '0) ? LAST_COL : col_r - 1'b1;
  end

  assign out_free = !out_valid_r || res_pop;
  assign init_busy = (state_r == ST_CLEAR) && !clr_emit_r;

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    col_nxt = col_r;
    text_nxt = text_r;
    clr_addr_nxt = clr_addr_r;
    clr_emit_nxt = clr_emit_r;
    ers_col_nxt = ers_col_r;
    rd_ok_nxt = rd_ok_r;
    cmd_pop = 1'b0;
    emit = 1'b0;
    em_reply = tdci_pkg::REPLY_NONE;
    em_cell = '0;
    em_odd = 1'b0;
    ram_we = 1'b0;
    ram_waddr = cell_addr(row_r, col_r);
    ram_wdata = tdci_pkg::CHAR_SPACE;
    ram_re = 1'b0;
    ram_raddr = cell_addr(cmd.row, cmd.col);

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = clr_emit_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.code == tdci_pkg::CMD_READ) begin
            ram_re = cmd.in_range;
            rd_ok_nxt = cmd.in_range;
            state_nxt = ST_READ;
          end else if (cmd.code == tdci_pkg::CMD_ACK) begin
            emit = 1'b1;
            em_reply = tdci_pkg::REPLY_GRANT;
          end else if (cmd.code == tdci_pkg::CMD_EOT) begin
            emit = 1'b1;
            text_nxt = 1'b0;
          end else if (cmd.code == tdci_pkg::CMD_ENQ) begin
            emit = 1'b1;
            em_reply = tdci_pkg::REPLY_ACK;
          end else if (cmd.code == tdci_pkg::CMD_STX) begin
            emit = 1'b1;
            text_nxt = 1'b1;
          end else if (cmd.code == tdci_pkg::CMD_ETX) begin
            // closes text and stores a marker even when text was closed
            emit = 1'b1;
            text_nxt = 1'b0;
            em_reply = tdci_pkg::REPLY_ACK;
            ram_we = 1'b1;
            ram_wdata = tdci_pkg::CHAR_ETX;
            row_nxt = right_row;
            col_nxt = right_col;
          end else if (!text_r) begin
            emit = 1'b1;
            em_odd = 1'b1;
          end else begin
            case (cmd.code)
              tdci_pkg::CMD_PRINT: begin
                emit = 1'b1;
                ram_we = 1'b1;
                ram_wdata = cmd.ch;
                row_nxt = right_row;
                col_nxt = right_col;
              end
              tdci_pkg::CMD_DC1: begin
                ers_col_nxt = col_r;
                state_nxt = ST_ERASE;
              end
              tdci_pkg::CMD_BS: begin
                emit = 1'b1;
                row_nxt = left_row;
                col_nxt = left_col;
              end
              tdci_pkg::CMD_DC4: begin
                emit = 1'b1;
                row_nxt = '0;
                col_nxt = '0;
              end
              tdci_pkg::CMD_DC3: begin
                emit = 1'b1;
                row_nxt = row_up;
              end
              tdci_pkg::CMD_LF: begin
                emit = 1'b1;
                row_nxt = row_dn;
              end
              tdci_pkg::CMD_CR: begin
                emit = 1'b1;
                ram_we = 1'b1;
                ram_wdata = tdci_pkg::CHAR_CR;
                row_nxt = right_row_dn;
                col_nxt = '0;
              end
              tdci_pkg::CMD_FF: begin
                row_nxt = '0;
                col_nxt = '0;
                clr_addr_nxt = '0;
                clr_emit_nxt = 1'b1;
                state_nxt = ST_CLEAR;
              end
              tdci_pkg::CMD_NUL: begin
                emit = 1'b1;
              end
              default: begin
                emit = 1'b1;
                em_odd = 1'b1;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          emit = 1'b1;
          em_cell = rd_ok_r ? ram_rdata : '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERASE: begin
        ram_we = 1'b1;
        ram_waddr = cell_addr(row_r, ers_col_r);
        ers_col_nxt = ers_col_r + 1'b1;
        if (ers_col_r == LAST_COL) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    emit_res.reply = em_reply;
    emit_res.cell_char = em_cell;
    emit_res.cursor_row = row_nxt;
    emit_res.cursor_col = col_nxt;
    emit_res.in_text = text_nxt;
    emit_res.unexpected = em_odd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r <= '0;
      col_r <= '0;
      text_r <= 1'b0;
      clr_addr_r <= '0;
      clr_emit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      text_r <= text_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_emit_r <= (state_nxt == ST_CLEAR) ? clr_emit_nxt : 1'b0;
      out_valid_r <= emit || (out_valid_r && !res_pop);
    end
  end

  always_ff @(posedge clk) begin
    ers_col_r <= ers_col_nxt;
    rd_ok_r <= rd_ok_nxt;
    if (emit) begin
      out_r <= emit_res;
    end
  end

  assign res_valid = out_valid_r;
  assign res = out_r;

  tdci_ram #(
    .WIDTH(tdci_pkg::CHAR_W),
    .DEPTH(tdci_pkg::NUM_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/text_display_control_interpreter.sv
// Top level of the text display control-code interpreter.
// Usage:
//  - Input queue: drive in_operation and its fields, raise push; a transaction
//    completes at a rising edge with push high and full low. in_operation 0 is
//    a received line byte (in_rx_byte), 1 reads the cell at in_read_row/col.
//  - Result queue: while empty is low the oldest result sits on the out_ ports;
//    raise pop to take it. Each input transaction yields exactly one result.
//  - Path from accept to empty going low: the command queue, then the result
//    register for cursor moves, stores and protocol bytes; cell reads pass the
//    READ state, DC1 erases the rest of the row and FF walks every cell first.
//  - Throughput: one byte item per cycle while results are popped at once;
//    reads wait in READ; one cell-store write port sets erase/clear lengths.
//  - A 2-entry command queue sits between decode and execution, and a result
//    register sits at the output, so the input side keeps taking transactions
//    while a result waits.
//  - Reset (rst_n low, synchronous) homes the cursor, closes text, drops any
//    queued transaction, then clears all NUM_CELLS (2000) cells to spaces, one
//    per cycle; full stays high during that clearing pass.
//  - When the receiver stalls, the result holds; execution pauses once the
//    result register is occupied, and full rises when the command queue fills.
`timescale 1ns / 1ps
module text_display_control_interpreter (
  input  logic                          clk,
  input  logic                          rst_n,
  // input queue
  input  logic                          push,
  output logic                          full,
  input  logic                          in_operation,
  input  logic [tdci_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic [tdci_pkg::ROW_W-1:0]    in_read_row,
  input  logic [tdci_pkg::COL_W-1:0]    in_read_col,
  // result queue
  output logic                          empty,
  input  logic                          pop,
  output logic [tdci_pkg::REPLY_W-1:0]  out_reply,
  output logic [tdci_pkg::CHAR_W-1:0]   out_cell_char,
  output logic [tdci_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tdci_pkg::COL_W-1:0]    out_cursor_col,
  output logic                          out_in_text,
  output logic                          out_unexpected
);

  logic           cmd_valid;
  logic           cmd_pop;
  tdci_pkg::cmd_t cmd;
  logic           init_busy;
  logic           res_valid;
  tdci_pkg::res_t res;

  // decode + command queue
  tdci_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .hold         (init_busy),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // execution, cell store and result register
  tdci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty = !res_valid;
  assign out_reply = res.reply;
  assign out_cell_char = res.cell_char;
  assign out_cursor_row = res.cursor_row;
  assign out_cursor_col = res.cursor_col;
  assign out_in_text = res.in_text;
  assign out_unexpected = res.unexpected;

endmodule

// File: rtl/tdci_checker.sv
// Port-level checks for the text display interpreter, bound to the top level.
`timescale 1ns / 1ps
module tdci_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [tdci_pkg::REPLY_W-1:0]  out_reply,
  input logic [tdci_pkg::CHAR_W-1:0]   out_cell_char,
  input logic [tdci_pkg::ROW_W-1:0]    out_cursor_row,
  input logic [tdci_pkg::COL_W-1:0]    out_cursor_col,
  input logic                          out_unexpected
);

  // reset empties the result side and blocks input for the clearing pass
  a_reset_state: assert property (@(posedge clk) !rst_n |=> (empty && full))
    else $error("result pending or input open right after reset");

  // cursor always inside the display
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((32'(out_cursor_row) < tdci_pkg::NUM_ROWS) &&
                (32'(out_cursor_col) < tdci_pkg::NUM_COLS)))
    else $error("cursor outside display");

  // a flagged byte never answers
  a_odd_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_unexpected) |-> (out_reply == tdci_pkg::REPLY_NONE))
    else $error("unexpected byte with a reply");

  // replies come only from byte items, which carry no cell character
  a_reply_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_reply != tdci_pkg::REPLY_NONE)) |-> (out_cell_char == '0))
    else $error("reply carries a cell character");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_reply) && $stable(out_cell_char) &&
                          $stable(out_cursor_row) && $stable(out_cursor_col)))
    else $error("stalled result changed");

endmodule

bind text_display_control_interpreter tdci_checker u_tdci_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_reply      (out_reply),
  .out_cell_char  (out_cell_char),
  .out_cursor_row (out_cursor_row),
  .out_cursor_col (out_cursor_col),
  .out_unexpected (out_unexpected)
);
